[hdl/card_number_luhn_validate_top_defines.svh]
// Assertion macros for the card number check block.
// Each macro assumes signals named clk and rst_n in the scope where it is used.
`ifndef CARD_NUMBER_LUHN_VALIDATE_TOP_DEFINES_SVH
`define CARD_NUMBER_LUHN_VALIDATE_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define LUHN_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LUHN_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LUHN_ASSERT(lbl, prop, msg)
`define LUHN_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[hdl/luhn_pkg.sv]
package luhn_pkg;

    localparam int IN_WIDTH           = 63;
    localparam int BCD_DIGITS         = 19;
    localparam int BCD_WIDTH          = 4 * BCD_DIGITS;
    localparam int DIGIT_IDX_W        = $clog2(BCD_DIGITS);
    localparam int STEP_CNT_W         = $clog2(IN_WIDTH);
    localparam int COUNT_WIDTH        = 5;
    localparam int SUM_WIDTH          = 8;
    localparam int TYPE_WIDTH         = 2;
    localparam int DEFAULT_MAX_DIGITS = 19;

    typedef logic [3:0] digit_t;

    typedef enum logic [TYPE_WIDTH-1:0] {
        CARD_UNKNOWN = 2'd0,
        CARD_LEN15   = 2'd1,
        CARD_LEN16_5 = 2'd2,
        CARD_LEAD4   = 2'd3
    } card_type_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SCAN,
        ST_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic                   load;
        logic                   conv;
        logic                   scan;
        logic [DIGIT_IDX_W-1:0] digit_idx;
        logic                   out_load;
    } dp_cmd_t;

    // Doubled digit folded back to a single digit, as the odd positions need.
    function automatic digit_t luhn_double(digit_t d);
        logic [4:0] dd;
        dd = {d, 1'b0};
        if (dd > 5'd9)
        begin
            return digit_t'(dd - 5'd9);
        end
        return digit_t'(dd);
    endfunction

endpackage

[hdl/luhn_if.sv]
interface luhn_card_if import luhn_pkg::*;;
    logic                valid;
    logic                ready;
    logic [IN_WIDTH-1:0] card_number;

    modport source (output valid, output card_number, input ready);
    modport sink (input valid, input card_number, output ready);
endinterface

interface luhn_verdict_if import luhn_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic [COUNT_WIDTH-1:0] digit_count;
    logic [SUM_WIDTH-1:0]   luhn_sum;
    logic                   is_valid;
    logic [TYPE_WIDTH-1:0]  card_type;

    modport source (output valid, output digit_count, output luhn_sum, output is_valid,
                    output card_type, input ready);
    modport sink (input valid, input digit_count, input luhn_sum, input is_valid,
                  input card_type, output ready);
endinterface

[hdl/luhn_ctrl.sv]
module luhn_ctrl import luhn_pkg::*;
#(
    parameter int MAX_DIGITS = DEFAULT_MAX_DIGITS
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    output dp_cmd_t cmd
);

    ctrl_state_t           state_reg, state_next;
    logic [STEP_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        in_ready      = 1'b0;
        cmd           = '0;
        cmd.digit_idx = cnt_reg[DIGIT_IDX_W-1:0];
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                cmd.conv = 1'b1;
                if (cnt_reg == STEP_CNT_W'(IN_WIDTH - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_SCAN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (cnt_reg == STEP_CNT_W'(MAX_DIGITS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_FINISH;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_FINISH:
            begin
                // Wait here only while the previous result has not been taken.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

[hdl/luhn_dp.sv]
module luhn_dp import luhn_pkg::*;
#(
    parameter int MAX_DIGITS = DEFAULT_MAX_DIGITS
)
(
    input  logic                   clk,
    input  logic [IN_WIDTH-1:0]    card_number,
    input  dp_cmd_t                cmd,
    output logic [COUNT_WIDTH-1:0] digit_count,
    output logic [SUM_WIDTH-1:0]   luhn_sum,
    output logic                   is_valid,
    output logic [TYPE_WIDTH-1:0]  card_type
);

    logic [IN_WIDTH-1:0]    bin_reg;
    logic [BCD_WIDTH-1:0]   bcd_reg;
    logic [BCD_WIDTH-1:0]   bcd_adj;
    digit_t                 prev_reg;
    digit_t                 hi_reg, lo_reg;
    digit_t                 thi_reg, tlo_reg;
    logic [COUNT_WIDTH-1:0] sig_reg;
    logic [SUM_WIDTH-1:0]   sum_reg;
    digit_t                 mod_reg;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [SUM_WIDTH-1:0]   luhn_sum_reg;
    logic                   is_valid_reg;
    card_type_t             card_type_reg;

    digit_t                 cur_digit;
    digit_t                 weighted;
    logic [4:0]             mod_sum;
    digit_t                 mod_next;
    logic                   overflow;
    logic [COUNT_WIDTH-1:0] count;
    digit_t                 lead_hi, lead_lo;
    card_type_t             kind;

    // Shift-and-add-3 correction, applied to every decimal digit at once.
    always_comb
    begin
        for (int k = 0; k < BCD_DIGITS; k++)
        begin
            if (bcd_reg[4*k +: 4] >= 4'd5)
            begin
                bcd_adj[4*k +: 4] = bcd_reg[4*k +: 4] + 4'd3;
            end
            else
            begin
                bcd_adj[4*k +: 4] = bcd_reg[4*k +: 4];
            end
        end
    end

    assign cur_digit = bcd_reg[3:0];
    assign weighted  = cmd.digit_idx[0] ? luhn_double(cur_digit) : cur_digit;
    assign mod_sum   = {1'b0, mod_reg} + {1'b0, weighted};
    assign mod_next  = (mod_sum >= 5'd10) ? digit_t'(mod_sum - 5'd10) : digit_t'(mod_sum);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            bin_reg  <= card_number;
            bcd_reg  <= '0;
            prev_reg <= '0;
            hi_reg   <= '0;
            lo_reg   <= '0;
            thi_reg  <= '0;
            tlo_reg  <= '0;
            sig_reg  <= '0;
            sum_reg  <= '0;
            mod_reg  <= '0;
        end
        else if (cmd.conv)
        begin
            bcd_reg <= {bcd_adj[BCD_WIDTH-2:0], bin_reg[IN_WIDTH-1]};
            bin_reg <= {bin_reg[IN_WIDTH-2:0], 1'b0};
        end
        else if (cmd.scan)
        begin
            bcd_reg  <= {4'd0, bcd_reg[BCD_WIDTH-1:4]};
            prev_reg <= cur_digit;
            sum_reg  <= sum_reg + SUM_WIDTH'(weighted);
            mod_reg  <= mod_next;
            if (cur_digit != '0)
            begin
                sig_reg <= COUNT_WIDTH'(cmd.digit_idx) + 1'b1;
                hi_reg  <= cur_digit;
                lo_reg  <= prev_reg;
            end
            if (cmd.digit_idx == DIGIT_IDX_W'(MAX_DIGITS - 1))
            begin
                thi_reg <= cur_digit;
                tlo_reg <= prev_reg;
            end
        end
    end

    // Digits left beyond the scanned ones mean the count saturates at the limit.
    assign overflow = |bcd_reg;
    assign count    = overflow ? COUNT_WIDTH'(MAX_DIGITS) : sig_reg;
    assign lead_hi  = overflow ? thi_reg : hi_reg;
    assign lead_lo  = overflow ? tlo_reg : lo_reg;

    always_comb
    begin
        priority if (count == 5'd15 && lead_hi == 4'd3 && (lead_lo == 4'd4 || lead_lo == 4'd7))
        begin
            kind = CARD_LEN15;
        end
        else if (count == 5'd16 && lead_hi == 4'd5 && lead_lo >= 4'd1 && lead_lo <= 4'd5)
        begin
            kind = CARD_LEN16_5;
        end
        else if ((count == 5'd13 || count == 5'd16) && lead_hi == 4'd4)
        begin
            kind = CARD_LEAD4;
        end
        else
        begin
            kind = CARD_UNKNOWN;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            count_reg     <= count;
            luhn_sum_reg  <= sum_reg;
            is_valid_reg  <= (mod_reg == '0);
            card_type_reg <= kind;
        end
    end

    assign digit_count = count_reg;
    assign luhn_sum    = luhn_sum_reg;
    assign is_valid    = is_valid_reg;
    assign card_type   = card_type_reg;

endmodule

[hdl/card_number_luhn_validate_top.sv]
// Luhn check of a card number. One item on the card channel carries a 63-bit binary card
// number; one item on the verdict channel returns the significant digit count, the Luhn sum,
// the validity flag (sum a multiple of ten) and the card type from the length and the two
// leading digits. An item is accepted, converted from binary to decimal by shift-and-add-3,
// one step per input bit, summed one decimal digit at a time, and its result registered in
// ST_FINISH, which waits while the previous verdict has not been taken. The block works on one
// item at a time; it takes the next card number while the previous verdict waits to be taken.
`include "card_number_luhn_validate_top_defines.svh"

module card_number_luhn_validate_top import luhn_pkg::*;
#(
    parameter int MAX_DIGITS = DEFAULT_MAX_DIGITS
)
(
    input logic          clk,
    input logic          rst_n,
    luhn_card_if.sink    card,
    luhn_verdict_if.source verdict
);

    dp_cmd_t cmd;

    luhn_ctrl #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (card.valid),
        .in_ready  (card.ready),
        .out_valid (verdict.valid),
        .out_ready (verdict.ready),
        .cmd       (cmd)
    );

    luhn_dp #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dp (
        .clk         (clk),
        .card_number (card.card_number),
        .cmd         (cmd),
        .digit_count (verdict.digit_count),
        .luhn_sum    (verdict.luhn_sum),
        .is_valid    (verdict.is_valid),
        .card_type   (verdict.card_type)
    );

    `LUHN_ASSERT(a_no_early_result, (card.valid && card.ready) |=> !cmd.out_load, "result loaded right after an item was accepted")
    `LUHN_ASSERT(a_no_overwrite, cmd.out_load |-> (!verdict.valid || verdict.ready), "unaccepted result overwritten")
    `LUHN_ASSERT(a_type_length, (verdict.valid && verdict.card_type != CARD_UNKNOWN) |-> (verdict.digit_count == 5'd13 || verdict.digit_count == 5'd15 || verdict.digit_count == 5'd16), "card type with impossible length")

endmodule
